>>> hdl/ssmf_pkg.sv
// ----------------------------------------------------------------------------
// ssmf_pkg
// Shared types, constants and the character-to-segment table of the
// seven-segment frame generator.
// ----------------------------------------------------------------------------
package ssmf_pkg;

    localparam int DIGITS    = 3;
    localparam int CHARS     = 3;
    localparam int EN_W      = 3;
    localparam int CNT_MAX   = (DIGITS < CHARS) ? DIGITS : CHARS;
    localparam int QDEPTH    = 2;

    localparam logic [7:0] SEG_A   = 8'h01;
    localparam logic [7:0] SEG_B   = 8'h02;
    localparam logic [7:0] SEG_C   = 8'h04;
    localparam logic [7:0] SEG_D   = 8'h08;
    localparam logic [7:0] SEG_E   = 8'h10;
    localparam logic [7:0] SEG_F   = 8'h20;
    localparam logic [7:0] SEG_G   = 8'h40;
    localparam logic [7:0] SEG_H   = 8'h80;
    localparam logic [7:0] ALL_SEG = 8'hFF;

    typedef logic [7:0]      seg_t;
    typedef logic [EN_W-1:0] en_t;

    // one classified request: glyphs and digit enables, plus saturated count
    typedef struct packed {
        seg_t [CHARS-1:0] seg;
        en_t  [CHARS-1:0] en;
        logic [1:0]       count;
    } entry_t;

    function automatic seg_t glyph(input logic [7:0] code);
        seg_t s;
        case (code)
            8'h61:   s = ALL_SEG & ~(SEG_D | SEG_H);
            8'h62:   s = ALL_SEG & ~(SEG_A | SEG_B | SEG_H);
            8'h63:   s = ALL_SEG & ~(SEG_B | SEG_C | SEG_G | SEG_H);
            8'h64:   s = ALL_SEG & ~(SEG_A | SEG_F | SEG_H);
            8'h65:   s = ALL_SEG & ~(SEG_B | SEG_C | SEG_H);
            8'h66:   s = ALL_SEG & ~(SEG_B | SEG_C | SEG_D | SEG_H);
            8'h30:   s = ALL_SEG & ~(SEG_G | SEG_H);
            8'h31:   s = SEG_B | SEG_C;
            8'h32:   s = ALL_SEG & ~(SEG_C | SEG_F | SEG_H);
            8'h33:   s = ALL_SEG & ~(SEG_F | SEG_E | SEG_H);
            8'h34:   s = ALL_SEG & ~(SEG_A | SEG_D | SEG_E | SEG_H);
            8'h35:   s = ALL_SEG & ~(SEG_B | SEG_E | SEG_H);
            8'h36:   s = ALL_SEG & ~(SEG_B | SEG_H);
            8'h37:   s = SEG_A | SEG_B | SEG_C;
            8'h38:   s = ALL_SEG & ~SEG_H;
            8'h39:   s = ALL_SEG & ~(SEG_E | SEG_H);
            8'h2E:   s = SEG_H;
            8'h00:   s = 8'h00;
            8'h6F:   s = 8'h00;
            8'h2A:   s = SEG_A | SEG_F | SEG_G | SEG_H;
            default: s = ALL_SEG & ~(SEG_C | SEG_D);
        endcase
        return s;
    endfunction

    // one-hot enable for character k of a request holding cnt characters
    function automatic en_t digit_en(input int k, input logic [1:0] cnt);
        int  pos;
        en_t e;
        pos = DIGITS - int'(cnt) + k;
        e   = '0;
        if (pos < EN_W)
        begin
            e[pos] = 1'b1;
        end
        return e;
    endfunction

endpackage

>>> hdl/ssmf_front.sv
// ----------------------------------------------------------------------------
// ssmf_front
// Accepts display requests, saturates the count and classifies each
// character into its segment byte and digit enable for the queue.
// ----------------------------------------------------------------------------
module ssmf_front (
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic [7:0]            char_first,
    input  logic [7:0]            char_second,
    input  logic [7:0]            char_third,
    input  logic [1:0]            char_count,
    input  logic                  q_full,
    output logic                  q_push,
    output ssmf_pkg::entry_t      q_entry
);

    logic [1:0]                    cnt_sat;
    logic [ssmf_pkg::CHARS-1:0][7:0] chars;

    assign chars = {char_third, char_second, char_first};

    always_comb
    begin
        if (int'(char_count) > ssmf_pkg::CNT_MAX)
        begin
            cnt_sat = 2'(ssmf_pkg::CNT_MAX);
        end
        else
        begin
            cnt_sat = char_count;
        end
    end

    always_comb
    begin
        q_entry.count = cnt_sat;
        for (int k = 0; k < ssmf_pkg::CHARS; k++)
        begin
            q_entry.seg[k] = ssmf_pkg::glyph(chars[k]);
            q_entry.en[k]  = ssmf_pkg::digit_en(k, cnt_sat);
        end
    end

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

endmodule

>>> hdl/ssmf_queue.sv
// ----------------------------------------------------------------------------
// ssmf_queue
// Two-entry request queue between the classifier and the frame sequencer.
// ----------------------------------------------------------------------------
module ssmf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ssmf_pkg::entry_t      push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output ssmf_pkg::entry_t      head_entry
);

    localparam int PTR_W = (ssmf_pkg::QDEPTH > 1) ? $clog2(ssmf_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(ssmf_pkg::QDEPTH + 1);

    ssmf_pkg::entry_t entries_reg [ssmf_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) == ssmf_pkg::QDEPTH - 1)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (int'(fill_reg) == ssmf_pkg::QDEPTH);
    assign head_valid = (fill_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hdl/ssmf_back.sv
// ----------------------------------------------------------------------------
// ssmf_back
// Frame sequencer: walks the head request one frame a cycle into the
// output register unless frame_stall holds it, closing each request with a blanking frame.
// ----------------------------------------------------------------------------
module ssmf_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  ssmf_pkg::entry_t      head_entry,
    output logic                  pop,
    output logic                  frame_valid,
    input  logic                  frame_stall,
    output logic [7:0]            segments,
    output logic [2:0]            digit_enable,
    output logic                  last
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] seg_reg, seg_next;
    logic [2:0] en_reg, en_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic       slot_free;
    logic       fire;
    logic       closing;

    assign slot_free = !out_valid_reg || !frame_stall;
    assign fire      = head_valid && slot_free;
    assign closing   = (idx_reg == head_entry.count);
    assign pop       = fire && closing;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        seg_next       = seg_reg;
        en_next        = en_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        if (slot_free)
        begin
            out_valid_next = head_valid;
        end
        if (fire)
        begin
            if (closing)
            begin
                seg_next  = '0;
                en_next   = '0;
                last_next = 1'b1;
                idx_next  = '0;
            end
            else
            begin
                seg_next  = head_entry.seg[idx_reg];
                en_next   = head_entry.en[idx_reg];
                last_next = 1'b0;
                idx_next  = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg  <= seg_next;
        en_reg   <= en_next;
        last_reg <= last_next;
    end

    assign frame_valid  = out_valid_reg;
    assign segments     = seg_reg;
    assign digit_enable = en_reg;
    assign last         = last_reg;

endmodule

>>> hdl/seven_segment_mux_frames.sv
// An accepted request is written into a queue entry; its first frame is then
// registered in the output register, when the queue is empty and the output register is free.
// Each request gives count+1 frames (one to four); the frame sequencer writes
// them one frame a cycle, unless frame_stall holds it, into the single output register.
// A two-entry queue lets requests be accepted while frames are still going out.
// Reset (rst_n low, asynchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
// seven_segment_mux_frames
// Turns display requests into per-digit segment frames plus a blanking frame.
// ----------------------------------------------------------------------------
module seven_segment_mux_frames (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [7:0] char_first,
    input  logic [7:0] char_second,
    input  logic [7:0] char_third,
    input  logic [1:0] char_count,
    output logic       frame_valid,
    input  logic       frame_stall,
    output logic [7:0] segments,
    output logic [2:0] digit_enable,
    output logic       last
);

    ssmf_pkg::entry_t push_entry;
    ssmf_pkg::entry_t head_entry;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             head_valid;

    ssmf_front u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .char_first  (char_first),
        .char_second (char_second),
        .char_third  (char_third),
        .char_count  (char_count),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    ssmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ssmf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (q_pop),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .segments     (segments),
        .digit_enable (digit_enable),
        .last         (last)
    );

endmodule

>>> hdl/ssmf_checker.sv
// ----------------------------------------------------------------------------
// ssmf_checker
// Port-level checks on the frame stream of seven_segment_mux_frames.
// ----------------------------------------------------------------------------
module ssmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       frame_valid,
    input logic       frame_stall,
    input logic [7:0] segments,
    input logic [2:0] digit_enable,
    input logic       last
);

    // hold a stalled frame
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_stall |=> frame_valid && $stable(segments)
            && $stable(digit_enable) && $stable(last))
        else $error("stalled frame changed");

    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && last |-> segments == 8'h00 && digit_enable == 3'b000)
        else $error("blanking frame not all off");

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !last |-> $onehot0(digit_enable))
        else $error("digit enable not one-hot");

    // digits of one request advance left to right
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && !frame_stall && !last) ##1 (frame_valid && !last)
            |-> ($past(digit_enable) == 3'b000) || (digit_enable > $past(digit_enable)))
        else $error("digit order broken");

    // no frames out of an idle block right after reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !frame_valid)
        else $error("frame valid after reset");

endmodule

bind seven_segment_mux_frames ssmf_checker u_ssmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .segments     (segments),
    .digit_enable (digit_enable),
    .last         (last)
);
